### hw/rtl/sac_pkg.sv
// shared types, constants and address helpers for the lru cache tag unit
// no dependencies
`timescale 1ns / 1ps
package sac_pkg;

  localparam int MAX_SETS   = 256;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_W     = 64;
  localparam int SET_W      = $clog2(MAX_SETS);
  localparam int WAY_W      = 3;
  localparam int WAYCNT_W   = 4;
  localparam int TAG_W      = ADDR_W - 2;
  localparam int AGE_W      = 3;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SB_W       = 4;
  localparam int OB_W       = 6;

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_FETCH  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAYS        = 2'd2,
    CFG_NONE        = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_CMP  = 3'b100
  } state_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0] age;
    logic [MAX_WAYS-1:0]            valid;
  } set_row_t;

  typedef struct packed {
    logic load_addr;
    logic rd_en;
    logic cmp_en;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  function automatic logic [SET_W-1:0] set_idx_of(input logic [ADDR_W-1:0] a,
                                                  input logic [SB_W-1:0] sb,
                                                  input logic [OB_W-1:0] ob);
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] m;
    s = a >> ob;
    m = (ADDR_W'(1) << sb) - ADDR_W'(1);
    return s[SET_W-1:0] & m[SET_W-1:0];
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] a,
                                             input logic [SB_W-1:0] sb,
                                             input logic [OB_W-1:0] ob);
    logic [OB_W:0]     sh;
    logic [ADDR_W-1:0] s;
    sh = {1'b0, ob} + (OB_W+1)'(sb);
    s  = (sh >= (OB_W+1)'(ADDR_W)) ? '0 : (a >> sh[OB_W-1:0]);
    return s[TAG_W-1:0];
  endfunction

  function automatic logic [WAYCNT_W-1:0] ways_clamp(input logic [WAYCNT_W-1:0] w);
    logic [WAYCNT_W-1:0] r;
    r = w;
    if (w == '0) r = WAYCNT_W'(1);
    if (w > WAYCNT_W'(MAX_WAYS)) r = WAYCNT_W'(MAX_WAYS);
    return r;
  endfunction

endpackage

### hw/rtl/sac_ctrl.sv
// access sequencer: accepts items, splits modify into two accesses
// depends on sac_pkg
`timescale 1ns / 1ps
module sac_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_command,
  input  sac_pkg::dp_stat_t stat,
  output sac_pkg::dp_cmd_t  cmd
);
  import sac_pkg::*;

  state_t state_r, state_nxt;
  logic   mod_r, mod_nxt;

  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = mod_r;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (cmd_t'(in_command) != CMD_FETCH)) begin
          cmd.load_addr = 1'b1;
          cmd.rd_en     = 1'b1;
          mod_nxt       = (cmd_t'(in_command) == CMD_MODIFY);
          state_nxt     = ST_CMP;
        end
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (stat.out_free) begin
          cmd.cmp_en = 1'b1;
          cmd.last   = !mod_r;
          mod_nxt    = 1'b0;
          state_nxt  = mod_r ? ST_RD : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mod_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mod_r   <= mod_nxt;
    end
  end

endmodule

### hw/rtl/sac_dp.sv
// tag store, lookup and lru update, counters, config and result register
// depends on sac_pkg
`timescale 1ns / 1ps
module sac_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sac_pkg::dp_cmd_t                 cmd,
  output sac_pkg::dp_stat_t                stat,
  input  logic [sac_pkg::ADDR_W-1:0]       in_address,
  input  logic                             cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_outcome,
  output logic [sac_pkg::WAY_W-1:0]        out_way_used,
  output logic [sac_pkg::CNT_W-1:0]        out_hits_total,
  output logic [sac_pkg::CNT_W-1:0]        out_misses_total,
  output logic [sac_pkg::CNT_W-1:0]        out_evictions_total,
  output logic                             out_last
);
  import sac_pkg::*;

  set_row_t            mem [MAX_SETS];
  logic [MAX_SETS-1:0] row_vld_r;
  set_row_t            rd_q_r;

  logic [SB_W-1:0]     sb_r;
  logic [OB_W-1:0]     ob_r;
  logic [WAYCNT_W-1:0] ways_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [CNT_W-1:0]    hits_r, misses_r, evicts_r;
  logic                out_valid_r;
  outcome_t            outcome_r;
  logic [WAY_W-1:0]    way_r;
  logic                last_r;

  logic [SET_W-1:0]    rd_idx, cur_idx;
  logic [TAG_W-1:0]    cur_tag;
  logic [WAYCNT_W-1:0] ways_eff;
  set_row_t            row, wr_row;
  logic                hit_f, emp_f, vic_f;
  logic [WAY_W-1:0]    hit_w, emp_w, vic_w, tgt_w;
  logic [AGE_W-1:0]    old_age;
  outcome_t            outcome_c;

  assign rd_idx   = set_idx_of(cmd.load_addr ? in_address : addr_r, sb_r, ob_r);
  assign cur_idx  = set_idx_of(addr_r, sb_r, ob_r);
  assign cur_tag  = tag_of(addr_r, sb_r, ob_r);
  assign ways_eff = ways_clamp(ways_r);
  assign row      = row_vld_r[cur_idx] ? rd_q_r :
                    set_row_t'{tag: rd_q_r.tag, age: '0, valid: '0};

  always_comb begin
    hit_f = 1'b0; emp_f = 1'b0; vic_f = 1'b0;
    hit_w = '0;   emp_w = '0;   vic_w = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WAYCNT_W'(i) < ways_eff) begin
        if (row.valid[i]) begin
          if (row.tag[i] == cur_tag) begin
            hit_f = 1'b1;
            hit_w = WAY_W'(i);
          end
          if (!vic_f || row.age[i] > row.age[vic_w]) begin
            vic_f = 1'b1;
            vic_w = WAY_W'(i);
          end
        end else if (!emp_f) begin
          emp_f = 1'b1;
          emp_w = WAY_W'(i);
        end
      end
    end
  end

  always_comb begin
    wr_row = row;
    if (hit_f || !emp_f) begin
      tgt_w     = hit_f ? hit_w : vic_w;
      outcome_c = hit_f ? OUT_HIT : OUT_EVICT;
      old_age   = row.age[tgt_w];
      for (int i = 0; i < MAX_WAYS; i++) begin
        if ((WAYCNT_W'(i) < ways_eff) && row.valid[i] && row.age[i] < old_age)
          wr_row.age[i] = row.age[i] + AGE_W'(1);
      end
    end else begin
      tgt_w     = emp_w;
      outcome_c = OUT_FILL;
      old_age   = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
        if ((WAYCNT_W'(i) < ways_eff) && row.valid[i] && row.age[i] < AGE_MAX)
          wr_row.age[i] = row.age[i] + AGE_W'(1);
      end
    end
    wr_row.valid[tgt_w] = 1'b1;
    wr_row.tag[tgt_w]   = cur_tag;
    wr_row.age[tgt_w]   = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rd_q_r <= mem[rd_idx];
    if (cmd.cmp_en) mem[cur_idx] <= wr_row;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_addr) addr_r <= in_address;
    if (cmd.cmp_en) begin
      outcome_r <= outcome_c;
      way_r     <= tgt_w;
      last_r    <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
      sb_r        <= SB_W'(4);
      ob_r        <= OB_W'(4);
      ways_r      <= WAYCNT_W'(1);
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SET_BITS:    sb_r   <= cfg_wdata[SB_W-1:0];
          CFG_OFFSET_BITS: ob_r   <= cfg_wdata;
          CFG_WAYS:        ways_r <= cfg_wdata[WAYCNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.cmp_en) begin
        row_vld_r[cur_idx] <= 1'b1;
        if (outcome_c == OUT_HIT) hits_r <= hits_r + CNT_W'(1);
        else misses_r <= misses_r + CNT_W'(1);
        if (outcome_c == OUT_EVICT) evicts_r <= evicts_r + CNT_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_free       = !out_valid_r || out_ready;
  assign out_valid           = out_valid_r;
  assign out_outcome         = outcome_r;
  assign out_way_used        = way_r;
  assign out_hits_total      = hits_r;
  assign out_misses_total    = misses_r;
  assign out_evictions_total = evicts_r;
  assign out_last            = last_r;

endmodule

### hw/rtl/set_assoc_lru_cache_tags_unit.sv
// sequence: set read on the accept edge, compare and write back in the compare state,
//   which waits while a result is untaken; a modify then reads and compares once more
// throughput: fetch one per cycle; a load, store or modify holds off the next item
//   until its last compare; the single set memory port is read then written per access
// reset: synchronous active low; valid ranks and counters clear at once via per-set
//   valid flops, no clearing pass; config returns to 4 set bits, 4 offset bits, 1 way
`timescale 1ns / 1ps
module set_assoc_lru_cache_tags_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_command,
  input  logic [sac_pkg::ADDR_W-1:0]     in_address,
  input  logic                           cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sac_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_outcome,
  output logic [sac_pkg::WAY_W-1:0]      out_way_used,
  output logic [sac_pkg::CNT_W-1:0]      out_hits_total,
  output logic [sac_pkg::CNT_W-1:0]      out_misses_total,
  output logic [sac_pkg::CNT_W-1:0]      out_evictions_total,
  output logic                           out_last
);
  import sac_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd)
  );

  sac_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_address          (in_address),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_outcome         (out_outcome),
    .out_way_used        (out_way_used),
    .out_hits_total      (out_hits_total),
    .out_misses_total    (out_misses_total),
    .out_evictions_total (out_evictions_total),
    .out_last            (out_last)
  );

endmodule

### hw/rtl/sac_checker.sv
// port-level checks for the lru cache tag unit, bound to the top level
// depends on sac_pkg
`timescale 1ns / 1ps
module sac_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_outcome,
  input logic       out_last
);
  import sac_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_outcome == OUT_HIT || out_outcome == OUT_FILL ||
                   out_outcome == OUT_EVICT))
    else $error("bad outcome code");

  a_modify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("item taken while modify pending");

endmodule

bind set_assoc_lru_cache_tags_unit sac_checker u_sac_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_outcome (out_outcome),
  .out_last    (out_last)
);
